// ----- rtl/core/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and codes of the first-fit heap allocator: request and
// response beat layouts, command codes and status codes.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int SIZE_W   = 11;
	localparam int OFFSET_W = 10;
	localparam int STATUS_W = 3;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ZERO_SIZE   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NULL_FREE   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DOUBLE_FREE = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NOT_START   = 3'd5;

	typedef struct packed {
		logic                cmd;
		logic [SIZE_W-1:0]   alloc_size;
		logic [OFFSET_W-1:0] data_offset;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [OFFSET_W-1:0] granted_offset;
		logic [SIZE_W-1:0]   granted_size;
	} rsp_t;

endpackage

// ----- rtl/core/ffha_seg_ram.sv -----
// ----------------------------------------------------------------------------
// ffha_seg_ram
// Segment table storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ffha_seg_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 25
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/ffha_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffha_ctrl
// Request sequencer: scans the segment table one entry at a time, then
// splits, merges and shifts entries through the table's one read and one write port.
// ----------------------------------------------------------------------------
module ffha_ctrl #(
	parameter int ARENA_BYTES  = 1024,
	parameter int HEADER_BYTES = 16,
	parameter int MAX_SEGMENTS = 64,
	localparam int AW = ($clog2(ARENA_BYTES) + 1 > 12) ? $clog2(ARENA_BYTES) + 1 : 12,
	localparam int IW = $clog2(MAX_SEGMENTS),
	localparam int EW = 2 * AW + 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  ffha_pkg::req_t  req,
	output logic            res_valid,
	input  logic            res_ready,
	output ffha_pkg::rsp_t  res,
	output logic            ram_we,
	output logic [IW-1:0]   ram_waddr,
	output logic [EW-1:0]   ram_wdata,
	output logic [IW-1:0]   ram_raddr,
	input  logic [EW-1:0]   ram_rdata
);

	localparam int CW = $clog2(MAX_SEGMENTS + 1);

	localparam logic [3:0] S_INIT = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_RD   = 4'd2;
	localparam logic [3:0] S_CHK  = 4'd3;
	localparam logic [3:0] S_NRD  = 4'd4;
	localparam logic [3:0] S_NCHK = 4'd5;
	localparam logic [3:0] S_WMRG = 4'd6;
	localparam logic [3:0] S_SRD  = 4'd7;
	localparam logic [3:0] S_SWR  = 4'd8;
	localparam logic [3:0] S_WNEW = 4'd9;
	localparam logic [3:0] S_WCUR = 4'd10;
	localparam logic [3:0] S_FIN  = 4'd11;
	localparam logic [3:0] S_OUT  = 4'd12;

	localparam logic [AW-1:0] HDR      = AW'(HEADER_BYTES);
	localparam logic [AW-1:0] INIT_SZ  = AW'(ARENA_BYTES - HEADER_BYTES);
	localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_SEGMENTS);

	logic [3:0]    state_q;
	logic          cmd_q;
	logic [AW-1:0] size_q;
	logic [AW-1:0] off_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] k_q;
	logic [IW-1:0] tgt_q;
	logic [1:0]    r_q;
	logic          dir_up_q;
	logic [AW-1:0] cur_start_q;
	logic [AW-1:0] cur_size_q;
	logic [AW-1:0] prev_start_q;
	logic [AW-1:0] prev_size_q;
	logic          prev_free_q;
	logic [AW-1:0] mrg_start_q;
	logic [AW-1:0] mrg_size_q;
	ffha_pkg::rsp_t res_q;

	logic [AW-1:0] rd_start;
	logic [AW-1:0] rd_size;
	logic          rd_free;
	logic          fit;
	logic          split;
	logic          match;
	logic [CW-1:0] idx_p1;
	logic          has_next;
	logic          nf;
	logic          pf;
	logic [AW-1:0] mrg_size;
	logic [CW:0]   dn_src;
	logic [CW-1:0] up_src;
	logic [CW-1:0] k_dec;
	logic [CW:0]   k_inc_end;
	logic [CW:0]   wmrg_end;

	assign rd_start = ram_rdata[EW-1 -: AW];
	assign rd_size  = ram_rdata[AW:1];
	assign rd_free  = ram_rdata[0];

	assign fit      = rd_free && (rd_size >= size_q);
	assign split    = ((rd_size - size_q) > HDR) && (count_q < MAX_CNT);
	assign match    = (rd_start + HDR) == off_q;
	assign idx_p1   = idx_q + CW'(1);
	assign has_next = idx_p1 < count_q;
	assign nf       = has_next && rd_free;
	assign pf       = (idx_q != '0) && prev_free_q;
	assign mrg_size = (pf ? prev_size_q + HDR : '0) + cur_size_q
		+ (nf ? HDR + rd_size : '0);

	assign up_src    = k_q - CW'(1);
	assign dn_src    = (CW+1)'(k_q) + (CW+1)'(r_q);
	assign k_dec     = k_q - CW'(1);
	assign k_inc_end = (CW+1)'(k_q) + (CW+1)'(1) + (CW+1)'(r_q);
	assign wmrg_end  = (CW+1)'(tgt_q) + (CW+1)'(1) + (CW+1)'(r_q);

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_OUT);
	assign res       = res_q;

	// table port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = idx_q[IW-1:0];
		case (state_q)
			S_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = {{AW{1'b0}}, INIT_SZ, 1'b1};
			end
			S_CHK: begin
				if (cmd_q == ffha_pkg::CMD_ALLOC && fit && !split) begin
					ram_we    = 1'b1;
					ram_waddr = idx_q[IW-1:0];
					ram_wdata = {rd_start, rd_size, 1'b0};
				end
			end
			S_NRD: begin
				ram_raddr = idx_p1[IW-1:0];
			end
			S_WMRG: begin
				ram_we    = 1'b1;
				ram_waddr = tgt_q;
				ram_wdata = {mrg_start_q, mrg_size_q, 1'b1};
			end
			S_SRD: begin
				ram_raddr = dir_up_q ? up_src[IW-1:0] : dn_src[IW-1:0];
			end
			S_SWR: begin
				ram_we    = 1'b1;
				ram_waddr = k_q[IW-1:0];
				ram_wdata = ram_rdata;
			end
			S_WNEW: begin
				ram_we    = 1'b1;
				ram_waddr = tgt_q + IW'(1);
				ram_wdata = {cur_start_q + HDR + size_q, cur_size_q - size_q - HDR, 1'b1};
			end
			S_WCUR: begin
				ram_we    = 1'b1;
				ram_waddr = tgt_q;
				ram_wdata = {cur_start_q, size_q, 1'b0};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			count_q     <= CW'(1);
			prev_free_q <= 1'b0;
		end else begin
			case (state_q)
				S_INIT: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_valid) begin
						cmd_q                <= req.cmd;
						size_q               <= AW'(req.alloc_size);
						off_q                <= AW'(req.data_offset);
						idx_q                <= '0;
						prev_free_q          <= 1'b0;
						res_q.granted_offset <= '0;
						res_q.granted_size   <= '0;
						if (req.cmd == ffha_pkg::CMD_ALLOC && req.alloc_size == '0) begin
							res_q.status <= ffha_pkg::ST_ZERO_SIZE;
							state_q      <= S_OUT;
						end else if (req.cmd == ffha_pkg::CMD_FREE && req.data_offset == '0) begin
							res_q.status <= ffha_pkg::ST_NULL_FREE;
							state_q      <= S_OUT;
						end else begin
							res_q.status <= ffha_pkg::ST_OK;
							state_q      <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (cmd_q == ffha_pkg::CMD_ALLOC) begin
						if (fit) begin
							cur_start_q              <= rd_start;
							cur_size_q               <= rd_size;
							tgt_q                    <= idx_q[IW-1:0];
							res_q.status             <= ffha_pkg::ST_OK;
							res_q.granted_offset     <= ffha_pkg::OFFSET_W'(rd_start + HDR);
							if (split) begin
								res_q.granted_size <= ffha_pkg::SIZE_W'(size_q);
								dir_up_q           <= 1'b1;
								k_q                <= count_q;
								state_q            <= (count_q > idx_p1) ? S_SRD : S_WNEW;
							end else begin
								res_q.granted_size <= ffha_pkg::SIZE_W'(rd_size);
								state_q            <= S_OUT;
							end
						end else if (has_next) begin
							idx_q   <= idx_p1;
							state_q <= S_RD;
						end else begin
							res_q.status <= ffha_pkg::ST_NO_SPACE;
							state_q      <= S_OUT;
						end
					end else begin
						if (match) begin
							if (rd_free) begin
								res_q.status <= ffha_pkg::ST_DOUBLE_FREE;
								state_q      <= S_OUT;
							end else begin
								cur_start_q <= rd_start;
								cur_size_q  <= rd_size;
								state_q     <= S_NRD;
							end
						end else begin
							// remember this entry as the left neighbour of the next one
							prev_start_q <= rd_start;
							prev_size_q  <= rd_size;
							prev_free_q  <= rd_free;
							if (has_next) begin
								idx_q   <= idx_p1;
								state_q <= S_RD;
							end else begin
								res_q.status <= ffha_pkg::ST_NOT_START;
								state_q      <= S_OUT;
							end
						end
					end
				end
				S_NRD: begin
					state_q <= S_NCHK;
				end
				S_NCHK: begin
					mrg_size_q  <= mrg_size;
					mrg_start_q <= pf ? prev_start_q : cur_start_q;
					tgt_q       <= pf ? IW'(idx_q - CW'(1)) : idx_q[IW-1:0];
					r_q         <= {1'b0, pf} + {1'b0, nf};
					dir_up_q    <= 1'b0;
					state_q     <= S_WMRG;
				end
				S_WMRG: begin
					k_q <= CW'(tgt_q) + CW'(1);
					if (r_q != 2'd0 && wmrg_end < (CW+1)'(count_q)) begin
						state_q <= S_SRD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_SRD: begin
					state_q <= S_SWR;
				end
				S_SWR: begin
					if (dir_up_q) begin
						k_q     <= k_dec;
						state_q <= (k_dec > idx_p1) ? S_SRD : S_WNEW;
					end else begin
						k_q     <= k_q + CW'(1);
						state_q <= (k_inc_end < (CW+1)'(count_q)) ? S_SRD : S_FIN;
					end
				end
				S_WNEW: begin
					state_q <= S_WCUR;
				end
				S_WCUR: begin
					count_q <= count_q + CW'(1);
					state_q <= S_OUT;
				end
				S_FIN: begin
					count_q      <= count_q - CW'(r_q);
					res_q.status <= ffha_pkg::ST_OK;
					state_q      <= S_OUT;
				end
				S_OUT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/first_fit_heap_allocator_top.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit arena allocator with split on allocate and neighbour merge on
// free, kept as an address-ordered segment table.
// ----------------------------------------------------------------------------
// One request at a time. An allocate scans the segments up to the first fit;
// when the fit is split it moves the table entries above it up, then writes
// the new free entry and the granted one. A free scans the segments up to the
// match, reads the right neighbour, writes the merged entry and moves the
// entries above it down. All of it goes through the one port pair of the
// segment table, and scan and shift together never pass the table once.
// After reset the block writes the initial whole-arena segment before it
// takes a request. Results leave through an output register, so a new
// request is taken while the last response beat waits.
module first_fit_heap_allocator_top #(
	parameter int ARENA_BYTES  = 1024,
	parameter int HEADER_BYTES = 16,
	parameter int MAX_SEGMENTS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  ffha_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output ffha_pkg::rsp_t rsp
);

	localparam int AW = ($clog2(ARENA_BYTES) + 1 > 12) ? $clog2(ARENA_BYTES) + 1 : 12;
	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int EW = 2 * AW + 1;

	logic           ctrl_vld;
	logic           ctrl_rdy;
	ffha_pkg::rsp_t ctrl_res;
	logic           ram_we;
	logic [IW-1:0]  ram_waddr;
	logic [EW-1:0]  ram_wdata;
	logic [IW-1:0]  ram_raddr;
	logic [EW-1:0]  ram_rdata;
	logic           out_valid_q;
	ffha_pkg::rsp_t rsp_q;

	ffha_ctrl #(
		.ARENA_BYTES  (ARENA_BYTES),
		.HEADER_BYTES (HEADER_BYTES),
		.MAX_SEGMENTS (MAX_SEGMENTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (ctrl_vld),
		.res_ready (ctrl_rdy),
		.res       (ctrl_res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	ffha_seg_ram #(
		.DEPTH (MAX_SEGMENTS),
		.WIDTH (EW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// output register: load when empty or being drained
	assign ctrl_rdy = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl_vld && ctrl_rdy) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_vld && ctrl_rdy) begin
			rsp_q <= ctrl_res;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_fail_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ffha_pkg::ST_OK
		|-> rsp.granted_offset == '0 && rsp.granted_size == '0)
		else $error("failed request carries a grant");

	a_idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl_vld && req_ready))
		else $error("sequencer takes a request while holding a result");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status <= ffha_pkg::ST_NOT_START)
		else $error("response status code out of range");
`endif

endmodule
